>>> hdl/mpd_pkg.sv
`timescale 1ns / 1ps

package mpd_pkg;

  // Fixed field widths
  localparam int SUM_W        = 32;
  localparam int SLOT_FIELD_W = 3;
  localparam int K_FIELD_W    = 4;
  localparam int CFG_IDX_W    = 4;
  localparam int CFG_DATA_W   = 32;

  // Counts of list slots; seven bits hold values up to 127
  localparam int CNT_W = 7;

  // Depth of the queue between front and back
  localparam int Q_DEPTH = 2;

  localparam logic [SUM_W-1:0] SUM_MAX = '1;

  // Parameter defaults
  localparam int K_MAX_DEF       = 8;
  localparam int SAMPLE_BITS_DEF = 16;
  localparam int INDEX_BITS_DEF  = 16;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_DIST = 4'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE_K = 4'd1;

  // Input action codes
  localparam logic ACT_PUSH = 1'b0;
  localparam logic ACT_READ = 1'b1;

  // Result kind codes
  localparam logic KIND_PAIR  = 1'b0;
  localparam logic KIND_ENTRY = 1'b1;

  typedef struct packed {
    logic is_read;
    logic last;
  } item_ctl_t;

  typedef enum logic {
    B_RUN,
    B_FIN
  } back_state_t;

endpackage

>>> hdl/mpd_in_if.sv
`timescale 1ns / 1ps

interface mpd_in_if #(
  parameter int SAMPLE_BITS = mpd_pkg::SAMPLE_BITS_DEF,
  parameter int INDEX_BITS  = mpd_pkg::INDEX_BITS_DEF
) ();
  logic                                valid;
  logic                                ready;
  logic                                action;
  logic [SAMPLE_BITS-1:0]              sample_a;
  logic [SAMPLE_BITS-1:0]              sample_b;
  logic                                last_sample;
  logic [INDEX_BITS-1:0]               first_index;
  logic [INDEX_BITS-1:0]               second_index;
  logic [mpd_pkg::SLOT_FIELD_W-1:0]    read_slot;

  modport source (
    output valid, action, sample_a, sample_b, last_sample, first_index, second_index,
           read_slot,
    input  ready
  );

  modport sink (
    input  valid, action, sample_a, sample_b, last_sample, first_index, second_index,
           read_slot,
    output ready
  );
endinterface

>>> hdl/mpd_out_if.sv
`timescale 1ns / 1ps

interface mpd_out_if #(
  parameter int INDEX_BITS = mpd_pkg::INDEX_BITS_DEF
) ();
  logic                                valid;
  logic                                ready;
  logic                                kind;
  logic [mpd_pkg::SUM_W-1:0]           squared_distance;
  logic                                inserted;
  logic [mpd_pkg::SLOT_FIELD_W-1:0]    insert_slot;
  logic                                abandoned;
  logic [mpd_pkg::SUM_W-1:0]           threshold_sq;
  logic [INDEX_BITS-1:0]               entry_first;
  logic [INDEX_BITS-1:0]               entry_second;

  modport source (
    output valid, kind, squared_distance, inserted, insert_slot, abandoned, threshold_sq,
           entry_first, entry_second,
    input  ready
  );

  modport sink (
    input  valid, kind, squared_distance, inserted, insert_slot, abandoned, threshold_sq,
           entry_first, entry_second,
    output ready
  );
endinterface

>>> hdl/mpd_cfg_if.sv
`timescale 1ns / 1ps

interface mpd_cfg_if ();
  logic                              valid;
  logic                              ready;
  logic [mpd_pkg::CFG_IDX_W-1:0]     index;
  logic [mpd_pkg::CFG_DATA_W-1:0]    data;

  modport source (
    output valid, index, data,
    input  ready
  );

  modport sink (
    input  valid, index, data,
    output ready
  );
endinterface

>>> hdl/mpd_front.sv
`timescale 1ns / 1ps

module mpd_front #(
  parameter int SAMPLE_BITS = mpd_pkg::SAMPLE_BITS_DEF,
  parameter int INDEX_BITS  = mpd_pkg::INDEX_BITS_DEF
) (
  mpd_in_if.sink                            in_ch,
  output logic                              push_valid,
  input  logic                              push_ready,
  output mpd_pkg::item_ctl_t                push_ctl,
  output logic [2*SAMPLE_BITS-1:0]          push_sq,
  output logic [INDEX_BITS-1:0]             push_first,
  output logic [INDEX_BITS-1:0]             push_second,
  output logic [mpd_pkg::SLOT_FIELD_W-1:0]  push_slot
);

  localparam int SQ_W = 2 * SAMPLE_BITS;

  logic [SAMPLE_BITS-1:0] diff;

  assign push_valid  = in_ch.valid;
  assign in_ch.ready = push_ready;

  // Classify the item; square of the sample difference is registered in the queue
  always_comb begin
    push_ctl.is_read = (in_ch.action == mpd_pkg::ACT_READ);
    push_ctl.last    = in_ch.last_sample;
    if (in_ch.sample_a >= in_ch.sample_b) begin
      diff = in_ch.sample_a - in_ch.sample_b;
    end else begin
      diff = in_ch.sample_b - in_ch.sample_a;
    end
    push_sq = SQ_W'(diff) * SQ_W'(diff);
  end

  assign push_first  = in_ch.first_index;
  assign push_second = in_ch.second_index;
  assign push_slot   = in_ch.read_slot;

endmodule

>>> hdl/mpd_queue.sv
`timescale 1ns / 1ps

module mpd_queue #(
  parameter int W = 8
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push_valid,
  output logic          push_ready,
  input  logic [W-1:0]  push_data,
  output logic          pop_valid,
  input  logic          pop_ready,
  output logic [W-1:0]  pop_data
);

  localparam int DEPTH = mpd_pkg::Q_DEPTH;
  localparam int PW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW    = $clog2(DEPTH + 1);

  logic [W-1:0]  mem_r [DEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          do_push, do_pop;

  assign push_ready = (cnt_r != CW'(DEPTH));
  assign pop_valid  = (cnt_r != '0);
  assign pop_data   = mem_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + CW'(1);
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

>>> hdl/mpd_back.sv
`timescale 1ns / 1ps

module mpd_back #(
  parameter int K_MAX       = mpd_pkg::K_MAX_DEF,
  parameter int SAMPLE_BITS = mpd_pkg::SAMPLE_BITS_DEF,
  parameter int INDEX_BITS  = mpd_pkg::INDEX_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              pop_valid,
  output logic                              pop_ready,
  input  mpd_pkg::item_ctl_t                pop_ctl,
  input  logic [2*SAMPLE_BITS-1:0]          pop_sq,
  input  logic [INDEX_BITS-1:0]             pop_first,
  input  logic [INDEX_BITS-1:0]             pop_second,
  input  logic [mpd_pkg::SLOT_FIELD_W-1:0]  pop_slot,
  input  logic [mpd_pkg::SUM_W-1:0]         min_dist_sq,
  input  logic [mpd_pkg::K_FIELD_W-1:0]     active_k,
  mpd_out_if.source                         out_ch
);

  localparam int SUM_W  = mpd_pkg::SUM_W;
  localparam int SQ_W   = 2 * SAMPLE_BITS;
  localparam int ADD_W  = ((SQ_W > SUM_W) ? SQ_W : SUM_W) + 1;
  localparam int SLOT_W = (K_MAX > 1) ? $clog2(K_MAX) : 1;
  localparam int CW     = mpd_pkg::CNT_W;
  localparam int SFW    = mpd_pkg::SLOT_FIELD_W;

  mpd_pkg::back_state_t state_r, state_nxt;

  logic [SUM_W-1:0]      sum_r, sum_nxt;
  logic                  stop_r, stop_nxt;
  logic [SUM_W-1:0]      dist_r [K_MAX];
  logic [SUM_W-1:0]      dist_nxt [K_MAX];
  logic [INDEX_BITS-1:0] pf_r [K_MAX];
  logic [INDEX_BITS-1:0] pf_nxt [K_MAX];
  logic [INDEX_BITS-1:0] ps_r [K_MAX];
  logic [INDEX_BITS-1:0] ps_nxt [K_MAX];
  logic [INDEX_BITS-1:0] hold_first_r, hold_first_nxt;
  logic [INDEX_BITS-1:0] hold_second_r, hold_second_nxt;

  logic                  out_valid_r, out_valid_nxt;
  logic                  o_kind_r, o_kind_nxt;
  logic [SUM_W-1:0]      o_sd_r, o_sd_nxt;
  logic                  o_ins_r, o_ins_nxt;
  logic [SFW-1:0]        o_islot_r, o_islot_nxt;
  logic                  o_aband_r, o_aband_nxt;
  logic [SUM_W-1:0]      o_thr_r, o_thr_nxt;
  logic [INDEX_BITS-1:0] o_ef_r, o_ef_nxt;
  logic [INDEX_BITS-1:0] o_es_r, o_es_nxt;

  logic [CW-1:0]         eff_k, km1, pos, rslot;
  logic [SUM_W-1:0]      thr, thr_after, add_sat;
  logic [ADD_W-1:0]      add_full;
  logic                  ins_ok, out_free, load;
  logic [SUM_W-1:0]      ins_dist [K_MAX];
  logic [INDEX_BITS-1:0] ins_pf [K_MAX];
  logic [INDEX_BITS-1:0] ins_ps [K_MAX];

  // Effective list size: zero acts as one, clamp at K_MAX
  always_comb begin
    if (active_k == '0) begin
      eff_k = CW'(1);
    end else if (CW'(active_k) > CW'(K_MAX)) begin
      eff_k = CW'(K_MAX);
    end else begin
      eff_k = CW'(active_k);
    end
  end

  assign km1 = eff_k - CW'(1);
  assign thr = dist_r[km1[SLOT_W-1:0]];

  // Saturating accumulate
  always_comb begin
    add_full = ADD_W'(sum_r) + ADD_W'(pop_sq);
    if (add_full[ADD_W-1:SUM_W] != '0) begin
      add_sat = mpd_pkg::SUM_MAX;
    end else begin
      add_sat = add_full[SUM_W-1:0];
    end
  end

  // Sorted insert of the finished pair into the list cells
  always_comb begin
    ins_ok = (sum_r < thr) && (sum_r > min_dist_sq);
    pos    = km1;
    for (int i = K_MAX - 1; i >= 0; i--) begin
      if ((CW'(i) < eff_k) && (dist_r[i] > sum_r)) begin
        pos = CW'(i);
      end
    end
    for (int i = 0; i < K_MAX; i++) begin
      ins_dist[i] = dist_r[i];
      ins_pf[i]   = pf_r[i];
      ins_ps[i]   = ps_r[i];
      if ((CW'(i) < eff_k) && (CW'(i) == pos)) begin
        ins_dist[i] = sum_r;
        ins_pf[i]   = hold_first_r;
        ins_ps[i]   = hold_second_r;
      end
    end
    for (int i = 1; i < K_MAX; i++) begin
      if ((CW'(i) < eff_k) && (CW'(i) > pos)) begin
        ins_dist[i] = dist_r[i-1];
        ins_pf[i]   = pf_r[i-1];
        ins_ps[i]   = ps_r[i-1];
      end
    end
    thr_after = ins_dist[km1[SLOT_W-1:0]];
  end

  // A read beyond the list size reads the last kept slot
  always_comb begin
    rslot = CW'(pop_slot);
    if (rslot >= eff_k) begin
      rslot = km1;
    end
  end

  assign out_free = !out_valid_r || out_ch.ready;

  always_comb begin
    state_nxt       = state_r;
    sum_nxt         = sum_r;
    stop_nxt        = stop_r;
    dist_nxt        = dist_r;
    pf_nxt          = pf_r;
    ps_nxt          = ps_r;
    hold_first_nxt  = hold_first_r;
    hold_second_nxt = hold_second_r;
    o_kind_nxt      = o_kind_r;
    o_sd_nxt        = o_sd_r;
    o_ins_nxt       = o_ins_r;
    o_islot_nxt     = o_islot_r;
    o_aband_nxt     = o_aband_r;
    o_thr_nxt       = o_thr_r;
    o_ef_nxt        = o_ef_r;
    o_es_nxt        = o_es_r;
    pop_ready       = 1'b0;
    load            = 1'b0;

    unique case (state_r)
      mpd_pkg::B_RUN: begin
        if (pop_valid) begin
          if (pop_ctl.is_read) begin
            if (out_free) begin
              pop_ready   = 1'b1;
              load        = 1'b1;
              o_kind_nxt  = mpd_pkg::KIND_ENTRY;
              o_sd_nxt    = dist_r[rslot[SLOT_W-1:0]];
              o_ins_nxt   = 1'b0;
              o_islot_nxt = '0;
              o_aband_nxt = 1'b0;
              o_thr_nxt   = thr;
              o_ef_nxt    = pf_r[rslot[SLOT_W-1:0]];
              o_es_nxt    = ps_r[rslot[SLOT_W-1:0]];
            end
          end else begin
            pop_ready = 1'b1;
            if (sum_r < thr) begin
              sum_nxt = add_sat;
            end else begin
              stop_nxt = 1'b1;
            end
            if (pop_ctl.last) begin
              hold_first_nxt  = pop_first;
              hold_second_nxt = pop_second;
              state_nxt       = mpd_pkg::B_FIN;
            end
          end
        end
      end
      mpd_pkg::B_FIN: begin
        if (out_free) begin
          load        = 1'b1;
          o_kind_nxt  = mpd_pkg::KIND_PAIR;
          o_sd_nxt    = sum_r;
          o_ins_nxt   = ins_ok;
          o_aband_nxt = stop_r;
          if (ins_ok) begin
            dist_nxt    = ins_dist;
            pf_nxt      = ins_pf;
            ps_nxt      = ins_ps;
            o_islot_nxt = pos[SFW-1:0];
            o_thr_nxt   = thr_after;
            o_ef_nxt    = hold_first_r;
            o_es_nxt    = hold_second_r;
          end else begin
            o_islot_nxt = '0;
            o_thr_nxt   = thr;
            o_ef_nxt    = '0;
            o_es_nxt    = '0;
          end
          sum_nxt   = '0;
          stop_nxt  = 1'b0;
          state_nxt = mpd_pkg::B_RUN;
        end
      end
      default: begin
        state_nxt = mpd_pkg::B_RUN;
      end
    endcase

    if (load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= mpd_pkg::B_RUN;
      sum_r       <= '0;
      stop_r      <= 1'b0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < K_MAX; i++) begin
        dist_r[i] <= mpd_pkg::SUM_MAX;
        pf_r[i]   <= '0;
        ps_r[i]   <= '0;
      end
    end else begin
      state_r     <= state_nxt;
      sum_r       <= sum_nxt;
      stop_r      <= stop_nxt;
      out_valid_r <= out_valid_nxt;
      dist_r      <= dist_nxt;
      pf_r        <= pf_nxt;
      ps_r        <= ps_nxt;
    end
  end

  always_ff @(posedge clk) begin
    hold_first_r  <= hold_first_nxt;
    hold_second_r <= hold_second_nxt;
    o_kind_r      <= o_kind_nxt;
    o_sd_r        <= o_sd_nxt;
    o_ins_r       <= o_ins_nxt;
    o_islot_r     <= o_islot_nxt;
    o_aband_r     <= o_aband_nxt;
    o_thr_r       <= o_thr_nxt;
    o_ef_r        <= o_ef_nxt;
    o_es_r        <= o_es_nxt;
  end

  assign out_ch.valid            = out_valid_r;
  assign out_ch.kind             = o_kind_r;
  assign out_ch.squared_distance = o_sd_r;
  assign out_ch.inserted         = o_ins_r;
  assign out_ch.insert_slot      = o_islot_r;
  assign out_ch.abandoned        = o_aband_r;
  assign out_ch.threshold_sq     = o_thr_r;
  assign out_ch.entry_first      = o_ef_r;
  assign out_ch.entry_second     = o_es_r;

endmodule

>>> hdl/motif_pair_distance_top_k.sv
`timescale 1ns / 1ps

// Early-abandon squared distance with a sorted list of the K best pairs.
// in_ch takes one item per transfer: a push (one sample pair of two series,
// last_sample on the final pair) or a read of one list slot. out_ch gives one
// result per read and per last sample; other pushes give none. cfg_ch writes
// the squared-distance floor (index 0) and active_k (index 1); it is always
// ready; the user must write it only while the block is idle, and the block
// itself does not enforce this. Items pass through a two-entry queue; the
// front squares the sample difference into it, the back accumulates and
// updates the list. The back accumulates a push as it takes it, takes a read
// only when the output register is free, and for a last sample adds a finish
// step (compare-and-shift across the list cells) in which it takes no item.
// From input transfer to result valid, an item passes through the queue and
// then the output register; a last sample also passes the finish step between.
// Reset clears the running sum, fills the list with all-ones distances and
// zero indices, sets the squared-distance floor to 0 and active_k to 1.
// A stalled receiver holds the result in the output register; pushes keep
// flowing until the next result needs that register, and then the queue
// fills and in_ch.ready drops.
module motif_pair_distance_top_k #(
  parameter int K_MAX       = mpd_pkg::K_MAX_DEF,
  parameter int SAMPLE_BITS = mpd_pkg::SAMPLE_BITS_DEF,
  parameter int INDEX_BITS  = mpd_pkg::INDEX_BITS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  mpd_in_if.sink    in_ch,
  mpd_out_if.source out_ch,
  mpd_cfg_if.sink   cfg_ch
);

  localparam int SQ_W  = 2 * SAMPLE_BITS;
  localparam int SFW   = mpd_pkg::SLOT_FIELD_W;
  localparam int QW    = $bits(mpd_pkg::item_ctl_t) + SQ_W + 2 * INDEX_BITS + SFW;

  logic [mpd_pkg::SUM_W-1:0]     lb_r, lb_nxt;
  logic [mpd_pkg::K_FIELD_W-1:0] k_r, k_nxt;

  mpd_pkg::item_ctl_t    f_ctl, b_ctl;
  logic                  f_valid, f_ready, b_valid, b_ready;
  logic [SQ_W-1:0]       f_sq, b_sq;
  logic [INDEX_BITS-1:0] f_first, f_second, b_first, b_second;
  logic [SFW-1:0]        f_slot, b_slot;
  logic [QW-1:0]         q_push_data, q_pop_data;

  // Configuration registers
  assign cfg_ch.ready = 1'b1;

  always_comb begin
    lb_nxt = lb_r;
    k_nxt  = k_r;
    if (cfg_ch.valid && cfg_ch.ready) begin
      unique case (cfg_ch.index)
        mpd_pkg::CFG_MIN_DIST: lb_nxt = cfg_ch.data[mpd_pkg::SUM_W-1:0];
        mpd_pkg::CFG_ACTIVE_K: k_nxt  = cfg_ch.data[mpd_pkg::K_FIELD_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lb_r <= '0;
      k_r  <= mpd_pkg::K_FIELD_W'(1);
    end else begin
      lb_r <= lb_nxt;
      k_r  <= k_nxt;
    end
  end

  mpd_front #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .INDEX_BITS  (INDEX_BITS)
  ) u_front (
    .in_ch       (in_ch),
    .push_valid  (f_valid),
    .push_ready  (f_ready),
    .push_ctl    (f_ctl),
    .push_sq     (f_sq),
    .push_first  (f_first),
    .push_second (f_second),
    .push_slot   (f_slot)
  );

  assign q_push_data = {f_ctl, f_sq, f_first, f_second, f_slot};

  mpd_queue #(
    .W (QW)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (f_valid),
    .push_ready (f_ready),
    .push_data  (q_push_data),
    .pop_valid  (b_valid),
    .pop_ready  (b_ready),
    .pop_data   (q_pop_data)
  );

  assign {b_ctl, b_sq, b_first, b_second, b_slot} = q_pop_data;

  mpd_back #(
    .K_MAX       (K_MAX),
    .SAMPLE_BITS (SAMPLE_BITS),
    .INDEX_BITS  (INDEX_BITS)
  ) u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .pop_valid   (b_valid),
    .pop_ready   (b_ready),
    .pop_ctl     (b_ctl),
    .pop_sq      (b_sq),
    .pop_first   (b_first),
    .pop_second  (b_second),
    .pop_slot    (b_slot),
    .min_dist_sq (lb_r),
    .active_k    (k_r),
    .out_ch      (out_ch)
  );

  // A list read never reports insert or abandon status
  a_read_fields: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.kind == mpd_pkg::KIND_ENTRY) |->
      (!out_ch.inserted && !out_ch.abandoned && out_ch.insert_slot == '0))
    else $error("list read result carries pair status");

  // An inserted pair lies strictly between the lower bound and the saturated sum
  a_insert_range: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.kind == mpd_pkg::KIND_PAIR && out_ch.inserted) |->
      (out_ch.squared_distance > lb_r &&
       out_ch.squared_distance != mpd_pkg::SUM_MAX))
    else $error("inserted pair distance out of range");

  // A pair that was not inserted reports no slot and no indices
  a_no_insert: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.kind == mpd_pkg::KIND_PAIR && !out_ch.inserted) |->
      (out_ch.insert_slot == '0 && out_ch.entry_first == '0 &&
       out_ch.entry_second == '0))
    else $error("rejected pair carries list fields");

  // No result straight out of reset
  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_ch.valid)
    else $error("result valid after reset");

endmodule
